FILE: sv/dld_pkg.sv
// ============================================================================
// dld_pkg
// Shared types and constants of the decimal long divider.
// ============================================================================
`default_nettype none

package dld_pkg;

    localparam int VALUE_W   = 31;
    localparam int FRAC_W    = 6;
    localparam int DIGIT_W   = 4;
    localparam int ADD_CNT_W = 4;
    localparam int RADIX     = 10;

    localparam logic [FRAC_W-1:0] FRAC_RESET = 6'd5;

    localparam logic PART_QUOTIENT = 1'b0;
    localparam logic PART_FRACTION = 1'b1;

    typedef struct packed {
        logic [VALUE_W-1:0] dividend;
        logic [VALUE_W-1:0] divisor_value;
    } in_beat_t;

    typedef struct packed {
        logic               part_kind;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               divide_error;
    } out_beat_t;

    typedef logic [FRAC_W-1:0] cfg_beat_t;

    typedef struct packed {
        logic load;
        logic quot_step;
        logic dig_step;
        logic emit_q;
        logic emit_d;
        logic last;
    } dp_cmd_t;

    typedef struct packed {
        logic div_zero;
        logic rem_zero;
        logic acc_zero;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/dld_stream_if.sv
// ============================================================================
// dld_stream_if
// Valid/ready channel carrying one payload beat.
// ============================================================================
`default_nettype none

interface dld_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/dld_datapath.sv
// ============================================================================
// dld_datapath
// Restoring quotient divider, ten-step digit accumulator and result register.
// ============================================================================
`default_nettype none

module dld_datapath #(
    parameter int VALUE_BITS = 31
) (
    input  wire logic                clk,
    input  wire dld_pkg::dp_cmd_t    cmd,
    input  wire dld_pkg::in_beat_t   in_beat,
    output dld_pkg::dp_status_t      status,
    output dld_pkg::out_beat_t       out_beat
);
    import dld_pkg::*;

    localparam int W = VALUE_BITS;

    logic [W-1:0]       quo_reg, quo_next;
    logic [W-1:0]       rem_reg, rem_next;
    logic [W-1:0]       div_reg, div_next;
    logic [W-1:0]       acc_reg, acc_next;
    logic [DIGIT_W-1:0] dig_reg, dig_next;
    out_beat_t          out_reg, out_next;

    logic [W:0] shift_val;
    logic [W:0] shift_diff;
    logic       shift_ge;
    logic [W:0] sum_val;
    logic [W:0] sum_diff;
    logic       sum_ge;

    assign shift_val  = {rem_reg, quo_reg[W-1]};
    assign shift_diff = shift_val - {1'b0, div_reg};
    assign shift_ge   = shift_val >= {1'b0, div_reg};
    assign sum_val    = {1'b0, acc_reg} + {1'b0, rem_reg};
    assign sum_diff   = sum_val - {1'b0, div_reg};
    assign sum_ge     = sum_val >= {1'b0, div_reg};

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        acc_next = acc_reg;
        dig_next = dig_reg;
        out_next = out_reg;

        if (cmd.load)
        begin
            quo_next = W'(in_beat.dividend);
            div_next = W'(in_beat.divisor_value);
            rem_next = '0;
        end

        if (cmd.quot_step)
        begin
            rem_next = shift_ge ? shift_diff[W-1:0] : shift_val[W-1:0];
            quo_next = {quo_reg[W-2:0], shift_ge};
        end

        if (cmd.dig_step)
        begin
            acc_next = sum_ge ? sum_diff[W-1:0] : sum_val[W-1:0];
            dig_next = dig_reg + DIGIT_W'(sum_ge);
        end

        if (cmd.emit_q)
        begin
            out_next.part_kind    = PART_QUOTIENT;
            out_next.value        = status.div_zero ? '0 : VALUE_W'(quo_reg);
            out_next.last         = cmd.last;
            out_next.divide_error = status.div_zero;
            acc_next              = '0;
            dig_next              = '0;
        end

        if (cmd.emit_d)
        begin
            out_next.part_kind    = PART_FRACTION;
            out_next.value        = VALUE_W'(dig_reg);
            out_next.last         = cmd.last;
            out_next.divide_error = 1'b0;
            rem_next              = acc_reg;
            acc_next              = '0;
            dig_next              = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        acc_reg <= acc_next;
        dig_reg <= dig_next;
        out_reg <= out_next;
    end

    assign status.div_zero = (div_reg == '0);
    assign status.rem_zero = (rem_reg == '0);
    assign status.acc_zero = (acc_reg == '0);
    assign out_beat        = out_reg;

endmodule

`default_nettype wire

FILE: sv/dld_controller.sv
// ============================================================================
// dld_controller
// Sequencer for quotient bits and fraction digits, result valid, precision.
// ============================================================================
`default_nettype none

module dld_controller #(
    parameter int VALUE_BITS = 31,
    parameter int MAX_DIGITS = 63
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_ready,
    output logic                           rsp_valid,
    input  wire logic                      rsp_ready,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire dld_pkg::cfg_beat_t        cfg_data,
    input  wire dld_pkg::dp_status_t       status,
    output dld_pkg::dp_cmd_t               cmd
);
    import dld_pkg::*;

    localparam int BIT_CNT_W = $clog2(VALUE_BITS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_QUOT   = 5'b00010,
        S_EMIT_Q = 5'b00100,
        S_DIGIT  = 5'b01000,
        S_EMIT_D = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [ADD_CNT_W-1:0]   add_cnt_reg, add_cnt_next;
    logic [FRAC_W-1:0]      emit_cnt_reg, emit_cnt_next;
    logic [FRAC_W-1:0]      frac_reg, frac_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    logic [FRAC_W-1:0] max_digits;
    logic [FRAC_W-1:0] limit;
    logic [FRAC_W-1:0] emit_cnt_inc;
    logic              out_free;
    logic              load_out;

    assign max_digits   = FRAC_W'(MAX_DIGITS);
    assign limit        = (frac_reg > max_digits) ? max_digits : frac_reg;
    assign emit_cnt_inc = emit_cnt_reg + 1'b1;
    assign out_free     = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next    = state_reg;
        bit_cnt_next  = bit_cnt_reg;
        add_cnt_next  = add_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        cmd           = '0;
        load_out      = 1'b0;
        req_ready     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = '0;
                    state_next   = S_QUOT;
                end
            end
            S_QUOT:
            begin
                cmd.quot_step = 1'b1;
                bit_cnt_next  = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_BITS - 1))
                begin
                    state_next = S_EMIT_Q;
                end
            end
            S_EMIT_Q:
            begin
                if (out_free)
                begin
                    cmd.emit_q    = 1'b1;
                    cmd.last      = status.div_zero || status.rem_zero || (limit == '0);
                    load_out      = 1'b1;
                    emit_cnt_next = '0;
                    add_cnt_next  = '0;
                    state_next    = cmd.last ? S_IDLE : S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                cmd.dig_step = 1'b1;
                add_cnt_next = add_cnt_reg + 1'b1;
                if (add_cnt_reg == ADD_CNT_W'(RADIX - 1))
                begin
                    state_next = S_EMIT_D;
                end
            end
            S_EMIT_D:
            begin
                if (out_free)
                begin
                    cmd.emit_d    = 1'b1;
                    cmd.last      = status.acc_zero || (emit_cnt_inc == limit);
                    load_out      = 1'b1;
                    emit_cnt_next = emit_cnt_inc;
                    add_cnt_next  = '0;
                    state_next    = cmd.last ? S_IDLE : S_DIGIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign cfg_ready = 1'b1;
    assign frac_next = cfg_valid ? cfg_data : frac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bit_cnt_reg   <= '0;
            add_cnt_reg   <= '0;
            emit_cnt_reg  <= '0;
            frac_reg      <= FRAC_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            add_cnt_reg   <= add_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            frac_reg      <= frac_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

FILE: sv/decimal_long_divider_top.sv
// ============================================================================
// decimal_long_divider_top
// Decimal long divider: integer quotient followed by fraction digits.
// ============================================================================
// Sequence: VALUE_BITS restoring division steps, then the quotient beat is
//   loaded; each fraction digit is built from 10 additions, then loaded.
// Loads wait while the result register holds an untaken beat. A single
//   shared divider loop: the next item is taken once the last beat is loaded.
// Reset: controller idle, result register empty, fraction_digits = 5.
`default_nettype none

module decimal_long_divider_top #(
    parameter int VALUE_BITS = 31,
    parameter int MAX_DIGITS = 63
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    dld_stream_if.sink    req,
    dld_stream_if.sink    cfg,
    dld_stream_if.source  rsp
);
    import dld_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    in_beat_t   in_beat;
    out_beat_t  out_beat;
    cfg_beat_t  cfg_data;

    assign in_beat  = req.data;
    assign cfg_data = cfg.data;
    assign rsp.data = out_beat;

    dld_controller #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd)
    );

    dld_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .in_beat  (in_beat),
        .status   (status),
        .out_beat (out_beat)
    );

endmodule

`default_nettype wire

FILE: test/tb_decimal_long_divider_top.sv
// ============================================================================
// tb_decimal_long_divider_top
// Self-checking bench for the decimal long divider: operand beats go in in
// random bursts, the quotient and fraction digits are predicted at
// acceptance and compared field by field as the response beats arrive,
// over several fraction-digit limits written between idle phases.
// ============================================================================
`default_nettype none

module tb_decimal_long_divider_top;

    import dld_pkg::*;

    localparam int VALUE_BITS   = 31;
    localparam int MAX_DIGITS   = 63;
    localparam int DRAIN_CYCLES = VALUE_BITS + 2 + 11 * MAX_DIGITS;
    localparam int MAX_REPORTS  = 60;

    localparam logic [VALUE_W-1:0] OPERAND_MAX = 31'h7FFF_FFFF;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_PULSE,
        SINK_CHOKE
    } sink_mode_e;

    logic clk;
    logic rst_n;

    dld_stream_if #(.payload_t(in_beat_t))  req_if ();
    dld_stream_if #(.payload_t(cfg_beat_t)) cfg_if ();
    dld_stream_if #(.payload_t(out_beat_t)) rsp_if ();

    decimal_long_divider_top #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .cfg  (cfg_if),
        .rsp  (rsp_if)
    );

    in_beat_t   operand_q [$];
    out_beat_t  expected_parts_q [$];
    cfg_beat_t  frac_limit_model;
    int         mismatch_count;
    int         burst_left;
    int         gap_left;
    sink_mode_e sink_mode;
    int         mode_left;
    out_beat_t  want_part;
    out_beat_t  got_part;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("decimal_long_divider_top verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: rsp %s mismatch, expected %0d got %0d", $time, what, want, got);
    endtask

    function automatic void predict_long_division(input in_beat_t op);
        logic [VALUE_W-1:0] rem;
        logic [VALUE_W:0]   acc;
        logic [VALUE_W-1:0] digit;
        int                 cap;
        int                 n;
        out_beat_t          part;
        if (op.divisor_value == '0)
        begin
            part = '{part_kind: PART_QUOTIENT, value: '0, last: 1'b1, divide_error: 1'b1};
            expected_parts_q.push_back(part);
        end
        else
        begin
            cap = (int'(frac_limit_model) > MAX_DIGITS) ? MAX_DIGITS : int'(frac_limit_model);
            rem = op.dividend % op.divisor_value;
            part.part_kind    = PART_QUOTIENT;
            part.value        = op.dividend / op.divisor_value;
            part.last         = (rem == '0) || (cap == 0);
            part.divide_error = 1'b0;
            expected_parts_q.push_back(part);
            n = 0;
            while (rem != '0 && n < cap)
            begin
                acc   = '0;
                digit = '0;
                repeat (RADIX)
                begin
                    acc = acc + rem;
                    if (acc >= op.divisor_value)
                    begin
                        acc   = acc - op.divisor_value;
                        digit = digit + 1'b1;
                    end
                end
                rem = acc[VALUE_W-1:0];
                n++;
                part.part_kind    = PART_FRACTION;
                part.value        = digit;
                part.last         = (rem == '0) || (n == cap);
                part.divide_error = 1'b0;
                expected_parts_q.push_back(part);
            end
        end
    endfunction

    // Operand driver: bursts with random gaps, limit tracked on config beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid     <= 1'b0;
            req_if.data      <= '0;
            frac_limit_model = FRAC_RESET;
            burst_left       = 0;
            gap_left         = 0;
        end
        else
        begin
            if (cfg_if.valid && cfg_if.ready)
                frac_limit_model = cfg_if.data;
            if (req_if.valid && req_if.ready)
            begin
                predict_long_division(req_if.data);
                void'(operand_q.pop_front());
            end
            if (!(req_if.valid && !req_if.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end
                else if (operand_q.size() != 0)
                begin
                    req_if.valid <= 1'b1;
                    req_if.data  <= operand_q[0];
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 12);
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1:       gap_left = $urandom_range(1, 4);
                            2:       gap_left = $urandom_range(5, 60);
                            default: gap_left = $urandom_range(60, 400);
                        endcase
                    end
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: check each beat, stall on a changing pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            sink_mode    = SINK_OPEN;
            mode_left    = 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got_part = rsp_if.data;
                if (expected_parts_q.size() == 0)
                begin
                    report_mismatch("unexpected beat, value", 0, got_part.value);
                end
                else
                begin
                    want_part = expected_parts_q.pop_front();
                    if (got_part.part_kind != want_part.part_kind)
                        report_mismatch("part_kind", want_part.part_kind, got_part.part_kind);
                    if (got_part.value != want_part.value)
                        report_mismatch("value", want_part.value, got_part.value);
                    if (got_part.last != want_part.last)
                        report_mismatch("last", want_part.last, got_part.last);
                    if (got_part.divide_error != want_part.divide_error)
                        report_mismatch("divide_error", want_part.divide_error,
                                        got_part.divide_error);
                end
            end
            if (mode_left == 0)
            begin
                sink_mode = sink_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (sink_mode)
                SINK_OPEN:  rsp_if.ready <= 1'b1;
                SINK_COIN:  rsp_if.ready <= ($urandom_range(0, 1) == 1);
                SINK_PULSE: rsp_if.ready <= (mode_left % 4 == 0);
                default:    rsp_if.ready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    task automatic wait_idle();
        while (operand_q.size() != 0 || req_if.valid || expected_parts_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input cfg_beat_t limit, input int count);
        in_beat_t           op;
        logic [VALUE_W-1:0] d;
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= limit;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
        repeat (count)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    op.dividend      = VALUE_W'($urandom);
                    op.divisor_value = '0;
                end
                1:
                begin
                    op.dividend      = VALUE_W'($urandom);
                    op.divisor_value = VALUE_W'($urandom);
                end
                2:
                begin
                    op.dividend      = VALUE_W'($urandom);
                    op.divisor_value = VALUE_W'($urandom_range(1, 20));
                end
                3:
                begin
                    d = VALUE_W'(1) << $urandom_range(0, 10);
                    repeat ($urandom_range(0, 6))
                        d = d * VALUE_W'(5);
                    op.dividend      = VALUE_W'($urandom_range(0, 100000));
                    op.divisor_value = d;
                end
                4:
                begin
                    d                = VALUE_W'($urandom_range(1, 65535));
                    op.divisor_value = d;
                    op.dividend      = d * VALUE_W'($urandom_range(0, 32767));
                end
                5:
                begin
                    op.divisor_value = VALUE_W'($urandom) | 31'h4000_0000;
                    op.dividend      = VALUE_W'($urandom) % op.divisor_value;
                end
                6:
                begin
                    op.dividend      = OPERAND_MAX - VALUE_W'($urandom_range(0, 15));
                    op.divisor_value = OPERAND_MAX - VALUE_W'($urandom_range(0, 15));
                end
                default:
                begin
                    op.dividend      = VALUE_W'($urandom_range(0, 10000));
                    op.divisor_value = VALUE_W'($urandom_range(1, 1000));
                end
            endcase
            operand_q.push_back(op);
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        mismatch_count = 0;
        cfg_if.valid  <= 1'b0;
        cfg_if.data   <= '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // Edge operands under the reset limit of five digits
        operand_q.push_back({31'd0, 31'd1});
        operand_q.push_back({31'd7, 31'd0});
        operand_q.push_back({31'd0, 31'd0});
        operand_q.push_back({OPERAND_MAX, 31'd0});
        operand_q.push_back({OPERAND_MAX, 31'd1});
        operand_q.push_back({OPERAND_MAX, OPERAND_MAX});
        operand_q.push_back({31'd0, OPERAND_MAX});
        operand_q.push_back({31'd1, OPERAND_MAX});
        operand_q.push_back({OPERAND_MAX - 31'd1, OPERAND_MAX});
        operand_q.push_back({OPERAND_MAX, OPERAND_MAX - 31'd1});
        operand_q.push_back({OPERAND_MAX, 31'd2});
        operand_q.push_back({31'd1, 31'd3});
        operand_q.push_back({31'd1, 31'd2});
        operand_q.push_back({31'd1, 31'd8});
        operand_q.push_back({31'd1, 31'd32});
        operand_q.push_back({31'd1, 31'd64});
        operand_q.push_back({31'd10, 31'd5});
        operand_q.push_back({31'd22, 31'd7});
        operand_q.push_back({31'd3, 31'd10});
        operand_q.push_back({31'h2AAA_AAAA, 31'h5555_5555});
        operand_q.push_back({31'h5555_5555, 31'h2AAA_AAAA});
        operand_q.push_back({31'd1, 31'h4000_0000});
        wait_idle();
        run_phase(6'd0, 30);
        run_phase(6'd63, 25);
        run_phase(6'd1, 40);
        run_phase(6'd9, 60);
        run_phase(cfg_beat_t'($urandom_range(2, 16)), 60);
        run_phase(cfg_beat_t'($urandom_range(2, 62)), 33);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("decimal_long_divider_top verification clean");
        else
            $display("decimal_long_divider_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
sv/dld_pkg.sv
sv/dld_stream_if.sv
sv/dld_datapath.sv
sv/dld_controller.sv
sv/decimal_long_divider_top.sv
test/tb_decimal_long_divider_top.sv
